// ----- rtl/lav_pkg.sv -----
package lav_pkg;

  // Word format of every coordinate and matrix element.
  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;

  // Unit vector components: magnitude up to 1.0, plus sign.
  localparam int unsigned UW = FB + 2;
  // Normalized magnitudes keep their leading one at bit NORM_W - 1.
  localparam int unsigned NORM_W = 31;
  localparam int unsigned SQ_W = 64;
  localparam int unsigned ROOT_STEPS = SQ_W / 2;
  localparam int unsigned LEN_W = SQ_W / 2;
  localparam int unsigned Q_W = FB + 1;

  // Intermediate widths of the matrix datapath.
  localparam int unsigned CP_W = UW + DW;
  localparam int unsigned C_W = CP_W + 1;
  localparam int unsigned SF_W = 2 * UW;
  localparam int unsigned C2_W = SF_W + 1;
  localparam int unsigned DOT_W = CP_W + 2;
  localparam int unsigned UUW = UW + 1;
  localparam int unsigned UE_W = UUW + DW;
  localparam int unsigned DU_W = UE_W + 2;

  localparam int unsigned ROW_W = 2;
  localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;
  localparam logic [DW-1:0] ONE = DW'(1) << FB;

  localparam logic signed [63:0] WMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

  typedef logic [3:0][DW-1:0] row_t;
  typedef row_t [3:0] matrix_t;

  // Divide by 2^FB, rounding half away from zero.
  function automatic logic signed [63:0] round_frac(input logic signed [63:0] p);
    logic [63:0] a;
    a = p[63] ? (64'd0 - p) : p;
    a = (a + (64'd1 << (FB - 1))) >> FB;
    return p[63] ? -$signed(a) : $signed(a);
  endfunction

  // Clamp to the signed word range.
  function automatic logic [DW-1:0] sat_word(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > WMAX) begin
      r = WMAX;
    end else if (v < WMIN) begin
      r = WMIN;
    end else begin
      r = v;
    end
    return r[DW-1:0];
  endfunction

endpackage

// ----- rtl/lav_in_if.sv -----
interface lav_in_if;
  logic valid;
  logic ready;
  logic signed [lav_pkg::DW-1:0] eye_x;
  logic signed [lav_pkg::DW-1:0] eye_y;
  logic signed [lav_pkg::DW-1:0] eye_z;
  logic signed [lav_pkg::DW-1:0] center_x;
  logic signed [lav_pkg::DW-1:0] center_y;
  logic signed [lav_pkg::DW-1:0] center_z;
  logic signed [lav_pkg::DW-1:0] up_x;
  logic signed [lav_pkg::DW-1:0] up_y;
  logic signed [lav_pkg::DW-1:0] up_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z,
    output ready
  );
endinterface

// ----- rtl/lav_out_if.sv -----
interface lav_out_if;
  logic valid;
  logic ready;
  logic [lav_pkg::ROW_W-1:0] row_index;
  logic signed [lav_pkg::DW-1:0] col0;
  logic signed [lav_pkg::DW-1:0] col1;
  logic signed [lav_pkg::DW-1:0] col2;
  logic signed [lav_pkg::DW-1:0] col3;
  logic last_row;

  modport source (
    output valid, row_index, col0, col1, col2, col3, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_index, col0, col1, col2, col3, last_row,
    output ready
  );
endinterface

// ----- rtl/lav_norm.sv -----
// Pipelined 3-vector normalizer: magnitude, power-of-two scaling, sum of
// squares, a bit-per-stage integer square root and a bit-per-stage divider.
module lav_norm #(
  parameter int unsigned IW = 33,
  parameter int unsigned SBW = 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic [2:0][IW-1:0] vec_i,
  input  logic [SBW-1:0] side_i,
  output logic valid_o,
  output logic [2:0][lav_pkg::UW-1:0] unit_o,
  output logic [SBW-1:0] side_o
);

  localparam int unsigned PW = $clog2(IW) + 1;

  typedef struct packed {
    logic [lav_pkg::SQ_W-1:0] x;
    logic [lav_pkg::SQ_W-1:0] r;
    logic [2:0][lav_pkg::NORM_W-1:0] mag;
    logic [2:0] neg;
    logic zero;
    logic [SBW-1:0] side;
  } root_t;

  typedef struct packed {
    logic [lav_pkg::LEN_W-1:0] den;
    logic [2:0][lav_pkg::LEN_W-1:0] rem;
    logic [2:0][lav_pkg::Q_W-1:0] low;
    logic [2:0][lav_pkg::Q_W-1:0] quo;
    logic [2:0] neg;
    logic zero;
    logic [SBW-1:0] side;
  } div_t;

  // Stage registers ahead of the root chain.
  logic a_v_q, b_v_q, c_v_q, d_v_q;
  logic [2:0][IW-1:0] a_mag_q, b_mag_q;
  logic [2:0] a_neg_q, b_neg_q, c_neg_q, d_neg_q;
  logic [SBW-1:0] a_side_q, b_side_q, c_side_q, d_side_q;
  logic [PW-1:0] b_pos_q;
  logic b_zero_q, c_zero_q, d_zero_q;
  logic [2:0][lav_pkg::NORM_W-1:0] c_mag_q, d_mag_q;
  logic [2:0][2*lav_pkg::NORM_W-1:0] d_sq_q;

  root_t root_q [lav_pkg::ROOT_STEPS+1];
  logic root_v_q [lav_pkg::ROOT_STEPS+1];
  div_t div_q [lav_pkg::Q_W+1];
  logic div_v_q [lav_pkg::Q_W+1];

  logic out_v_q;
  logic [2:0][lav_pkg::UW-1:0] out_q;
  logic [SBW-1:0] out_side_q;

  // Leading-one position of the three magnitudes together.
  logic [IW-1:0] or_mag;
  logic [PW-1:0] pos_d;
  always_comb begin
    or_mag = a_mag_q[0] | a_mag_q[1] | a_mag_q[2];
    pos_d = '0;
    for (int b = 0; b < IW; b++) begin
      if (or_mag[b]) begin
        pos_d = PW'(b);
      end
    end
  end

  // Scale so that the largest magnitude has its leading one at the top bit.
  logic [2:0][lav_pkg::NORM_W-1:0] scaled;
  logic [IW+lav_pkg::NORM_W-1:0] ext [3];
  logic [IW+lav_pkg::NORM_W-1:0] shr [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = {b_mag_q[i], {lav_pkg::NORM_W{1'b0}}};
      shr[i] = ext[i] >> (b_pos_q + PW'(1));
      scaled[i] = shr[i][lav_pkg::NORM_W-1:0];
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      root_v_q[0] <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      root_v_q[0] <= d_v_q;
    end
  end

  // Front stages: magnitude, leading one, shift, squares, sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a_neg_q[i] <= vec_i[i][IW-1];
        a_mag_q[i] <= vec_i[i][IW-1] ? (IW'(0) - vec_i[i]) : vec_i[i];
        d_sq_q[i] <= (2*lav_pkg::NORM_W)'(c_mag_q[i]) * (2*lav_pkg::NORM_W)'(c_mag_q[i]);
      end
      a_side_q <= side_i;
      b_mag_q <= a_mag_q;
      b_neg_q <= a_neg_q;
      b_side_q <= a_side_q;
      b_pos_q <= pos_d;
      b_zero_q <= (or_mag == '0);
      c_mag_q <= scaled;
      c_neg_q <= b_neg_q;
      c_zero_q <= b_zero_q;
      c_side_q <= b_side_q;
      d_mag_q <= c_mag_q;
      d_neg_q <= c_neg_q;
      d_zero_q <= c_zero_q;
      d_side_q <= c_side_q;
      root_q[0].x <= lav_pkg::SQ_W'(d_sq_q[0]) + lav_pkg::SQ_W'(d_sq_q[1])
                     + lav_pkg::SQ_W'(d_sq_q[2]);
      root_q[0].r <= '0;
      root_q[0].mag <= d_mag_q;
      root_q[0].neg <= d_neg_q;
      root_q[0].zero <= d_zero_q;
      root_q[0].side <= d_side_q;
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = 0; k < lav_pkg::ROOT_STEPS; k++) begin : g_root
    localparam logic [lav_pkg::SQ_W-1:0] RBIT = lav_pkg::SQ_W'(1) << (lav_pkg::SQ_W - 2 - 2*k);
    logic [lav_pkg::SQ_W-1:0] trial;
    logic take;
    assign trial = root_q[k].r + RBIT;
    assign take = root_q[k].x >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        root_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        root_v_q[k+1] <= root_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k+1].mag <= root_q[k].mag;
        root_q[k+1].neg <= root_q[k].neg;
        root_q[k+1].zero <= root_q[k].zero;
        root_q[k+1].side <= root_q[k].side;
        if (take) begin
          root_q[k+1].x <= root_q[k].x - trial;
          root_q[k+1].r <= (root_q[k].r >> 1) + RBIT;
        end else begin
          root_q[k+1].x <= root_q[k].x;
          root_q[k+1].r <= root_q[k].r >> 1;
        end
      end
    end
  end

  // Divider setup: rounded numerator and the first partial remainder.
  logic [lav_pkg::LEN_W-1:0] len;
  logic [lav_pkg::NORM_W+lav_pkg::FB:0] num [3];
  assign len = root_q[lav_pkg::ROOT_STEPS].r[lav_pkg::LEN_W-1:0];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, root_q[lav_pkg::ROOT_STEPS].mag[i], {lav_pkg::FB{1'b0}}}
               + (lav_pkg::NORM_W+lav_pkg::FB+1)'(len >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else if (en_i) begin
      div_v_q[0] <= root_v_q[lav_pkg::ROOT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q[0].den <= len;
      for (int i = 0; i < 3; i++) begin
        div_q[0].rem[i] <= lav_pkg::LEN_W'(num[i][lav_pkg::NORM_W+lav_pkg::FB:lav_pkg::Q_W]);
        div_q[0].low[i] <= num[i][lav_pkg::Q_W-1:0];
      end
      div_q[0].quo <= '0;
      div_q[0].neg <= root_q[lav_pkg::ROOT_STEPS].neg;
      div_q[0].zero <= root_q[lav_pkg::ROOT_STEPS].zero;
      div_q[0].side <= root_q[lav_pkg::ROOT_STEPS].side;
    end
  end

  // Restoring division, one quotient bit per stage for each component.
  for (genvar j = 0; j < lav_pkg::Q_W; j++) begin : g_div
    logic [lav_pkg::LEN_W:0] t [3];
    logic [lav_pkg::LEN_W:0] diff [3];
    logic [2:0] ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {div_q[j].rem[i], div_q[j].low[i][lav_pkg::Q_W-1-j]};
        diff[i] = t[i] - {1'b0, div_q[j].den};
        ge[i] = t[i] >= {1'b0, div_q[j].den};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        div_v_q[j+1] <= div_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[j+1].den <= div_q[j].den;
        div_q[j+1].low <= div_q[j].low;
        div_q[j+1].neg <= div_q[j].neg;
        div_q[j+1].zero <= div_q[j].zero;
        div_q[j+1].side <= div_q[j].side;
        for (int i = 0; i < 3; i++) begin
          div_q[j+1].rem[i] <= ge[i] ? diff[i][lav_pkg::LEN_W-1:0]
                                     : t[i][lav_pkg::LEN_W-1:0];
          div_q[j+1].quo[i] <= {div_q[j].quo[i][lav_pkg::Q_W-2:0], ge[i]};
        end
      end
    end
  end

  // Sign restore; an all-zero vector gives zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= div_v_q[lav_pkg::Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (div_q[lav_pkg::Q_W].zero) begin
          out_q[i] <= '0;
        end else if (div_q[lav_pkg::Q_W].neg[i]) begin
          out_q[i] <= lav_pkg::UW'(0) - {1'b0, div_q[lav_pkg::Q_W].quo[i]};
        end else begin
          out_q[i] <= {1'b0, div_q[lav_pkg::Q_W].quo[i]};
        end
      end
      out_side_q <= div_q[lav_pkg::Q_W].side;
    end
  end

  assign valid_o = out_v_q;
  assign unit_o = out_q;
  assign side_o = out_side_q;

endmodule

// ----- rtl/lav_rows.sv -----
// Holds one finished matrix and sends it as four row transactions.
module lav_rows (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  output logic ready_o,
  input  lav_pkg::matrix_t mat_i,
  lav_out_if.source out_o
);

  logic busy_q;
  logic [lav_pkg::ROW_W-1:0] row_q;
  lav_pkg::matrix_t mat_q;
  logic row_done;

  assign row_done = busy_q && out_o.ready;
  assign ready_o = !busy_q || (row_done && (row_q == lav_pkg::LAST_ROW));

  // Row sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q <= '0;
    end else if (load_i && ready_o) begin
      busy_q <= 1'b1;
      row_q <= '0;
    end else if (row_done) begin
      if (row_q == lav_pkg::LAST_ROW) begin
        busy_q <= 1'b0;
      end else begin
        row_q <= row_q + lav_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      mat_q <= mat_i;
    end
  end

  // Output row selection.
  assign out_o.valid = busy_q;
  assign out_o.row_index = row_q;
  assign out_o.col0 = mat_q[row_q][0];
  assign out_o.col1 = mat_q[row_q][1];
  assign out_o.col2 = mat_q[row_q][2];
  assign out_o.col3 = mat_q[row_q][3];
  assign out_o.last_row = (row_q == lav_pkg::LAST_ROW);

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_done && (row_q != lav_pkg::LAST_ROW)) |=>
      (busy_q && (row_q == $past(row_q) + lav_pkg::ROW_W'(1))))
    else $error("row counter did not advance");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_done && (row_q == lav_pkg::LAST_ROW) && !load_i) |=> !busy_q)
    else $error("holder stayed busy after the last row");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && ready_o) |=> (busy_q && (row_q == '0)))
    else $error("new matrix does not start at row zero");

endmodule

// ----- rtl/look_at_view_matrix_core.sv -----
// Channel   Dir  Modport  Transaction
// in_i      in   sink     eye, center and up vectors, signed Q16.16
// out_o     out  source   one matrix row: row_index, col0..col3, last_row
//
// Each input transaction yields four row transactions, rows 0 to 3.
// Items overlap; in steady state a new item enters as the output holder
// takes a matrix; the holder sends one row per cycle while out_o is ready.
// Reset is asynchronous and active low; it clears only valid and row state.
// Out_o stalls with a full tail freeze the pipe; no item is lost or repeated.
module look_at_view_matrix_core (
  input  logic clk_i,
  input  logic rst_ni,
  lav_in_if.sink in_i,
  lav_out_if.source out_o
);

  localparam int unsigned DW = lav_pkg::DW;
  localparam int unsigned UW = lav_pkg::UW;

  logic en;
  logic rows_ready;

  // Stage 0: input capture.
  logic v0_q;
  logic [2:0][DW-1:0] eye0_q, ctr0_q, up0_q;
  // Stage 1: direction.
  logic v1_q;
  logic [2:0][DW:0] d1_q;
  logic [2:0][DW-1:0] eye1_q, up1_q;
  // First normalizer.
  logic n1_v;
  logic [2:0][UW-1:0] f_n;
  logic [6*DW-1:0] n1_side;
  logic [2:0][DW-1:0] eye_n1, up_n1;
  // Stages 2 and 3: cross(f, up).
  logic v2_q, v3_q;
  logic [5:0][lav_pkg::CP_W-1:0] p2_q;
  logic [2:0][UW-1:0] f2_q, f3_q;
  logic [2:0][DW-1:0] eye2_q, eye3_q;
  logic [2:0][lav_pkg::C_W-1:0] c3_q;
  // Second normalizer.
  logic n2_v;
  logic [2:0][UW-1:0] s_n, f_n2;
  logic [3*UW+3*DW-1:0] n2_side;
  logic [2:0][DW-1:0] eye_n2;
  // Stages 4 to 9: u, row 3 and the assembled matrix.
  logic v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic [5:0][lav_pkg::SF_W-1:0] sf4_q;
  logic [2:0][lav_pkg::CP_W-1:0] se4_q, fe4_q;
  logic [2:0][UW-1:0] s4_q, f4_q, s5_q, f5_q, s6_q, f6_q, s7_q, f7_q, s8_q, f8_q;
  logic [2:0][DW-1:0] eye4_q, eye5_q, eye6_q;
  logic [2:0][lav_pkg::C2_W-1:0] c5_q;
  logic [lav_pkg::DOT_W-1:0] ds5_q, df5_q;
  logic [2:0][lav_pkg::UUW-1:0] u6_q, u7_q, u8_q;
  logic [DW-1:0] l0_6_q, l2_6_q, l0_7_q, l2_7_q, l0_8_q, l2_8_q;
  logic [2:0][lav_pkg::UE_W-1:0] ue7_q;
  logic [lav_pkg::DU_W-1:0] du8_q;
  lav_pkg::matrix_t mat9_q;

  // The pipeline moves whenever its tail is empty or handed over.
  assign en = !v9_q || rows_ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= n1_v;
      v3_q <= v2_q;
      v4_q <= n2_v;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  // Input capture and direction center - eye.
  always_ff @(posedge clk_i) begin
    if (en) begin
      eye0_q <= {in_i.eye_z, in_i.eye_y, in_i.eye_x};
      ctr0_q <= {in_i.center_z, in_i.center_y, in_i.center_x};
      up0_q <= {in_i.up_z, in_i.up_y, in_i.up_x};
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= (DW+1)'($signed(ctr0_q[i])) - (DW+1)'($signed(eye0_q[i]));
      end
      eye1_q <= eye0_q;
      up1_q <= up0_q;
    end
  end

  lav_norm #(
    .IW (DW + 1),
    .SBW(6 * DW)
  ) u_norm_f (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v1_q),
    .vec_i  (d1_q),
    .side_i ({eye1_q, up1_q}),
    .valid_o(n1_v),
    .unit_o (f_n),
    .side_o (n1_side)
  );
  assign {eye_n1, up_n1} = n1_side;

  // Products and differences of cross(f, up).
  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q[0] <= $signed(f_n[1]) * $signed(up_n1[2]);
      p2_q[1] <= $signed(f_n[2]) * $signed(up_n1[1]);
      p2_q[2] <= $signed(f_n[2]) * $signed(up_n1[0]);
      p2_q[3] <= $signed(f_n[0]) * $signed(up_n1[2]);
      p2_q[4] <= $signed(f_n[0]) * $signed(up_n1[1]);
      p2_q[5] <= $signed(f_n[1]) * $signed(up_n1[0]);
      f2_q <= f_n;
      eye2_q <= eye_n1;
      for (int i = 0; i < 3; i++) begin
        c3_q[i] <= lav_pkg::C_W'($signed(p2_q[2*i])) - lav_pkg::C_W'($signed(p2_q[2*i+1]));
      end
      f3_q <= f2_q;
      eye3_q <= eye2_q;
    end
  end

  lav_norm #(
    .IW (lav_pkg::C_W),
    .SBW(3 * UW + 3 * DW)
  ) u_norm_s (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v3_q),
    .vec_i  (c3_q),
    .side_i ({f3_q, eye3_q}),
    .valid_o(n2_v),
    .unit_o (s_n),
    .side_o (n2_side)
  );
  assign {f_n2, eye_n2} = n2_side;

  // cross(s, f) products and the terms of dot(s, eye) and dot(f, eye).
  always_ff @(posedge clk_i) begin
    if (en) begin
      sf4_q[0] <= $signed(s_n[1]) * $signed(f_n2[2]);
      sf4_q[1] <= $signed(s_n[2]) * $signed(f_n2[1]);
      sf4_q[2] <= $signed(s_n[2]) * $signed(f_n2[0]);
      sf4_q[3] <= $signed(s_n[0]) * $signed(f_n2[2]);
      sf4_q[4] <= $signed(s_n[0]) * $signed(f_n2[1]);
      sf4_q[5] <= $signed(s_n[1]) * $signed(f_n2[0]);
      for (int i = 0; i < 3; i++) begin
        se4_q[i] <= $signed(s_n[i]) * $signed(eye_n2[i]);
        fe4_q[i] <= $signed(f_n2[i]) * $signed(eye_n2[i]);
      end
      s4_q <= s_n;
      f4_q <= f_n2;
      eye4_q <= eye_n2;
    end
  end

  // Sums of products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c5_q[i] <= lav_pkg::C2_W'($signed(sf4_q[2*i]))
                   - lav_pkg::C2_W'($signed(sf4_q[2*i+1]));
      end
      ds5_q <= lav_pkg::DOT_W'($signed(se4_q[0])) + lav_pkg::DOT_W'($signed(se4_q[1]))
               + lav_pkg::DOT_W'($signed(se4_q[2]));
      df5_q <= lav_pkg::DOT_W'($signed(fe4_q[0])) + lav_pkg::DOT_W'($signed(fe4_q[1]))
               + lav_pkg::DOT_W'($signed(fe4_q[2]));
      s5_q <= s4_q;
      f5_q <= f4_q;
      eye5_q <= eye4_q;
    end
  end

  // Rounding of u and of the s and f translation terms.
  logic signed [63:0] u_rnd [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_rnd[i] = lav_pkg::round_frac(64'($signed(c5_q[i])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u6_q[i] <= u_rnd[i][lav_pkg::UUW-1:0];
      end
      l0_6_q <= lav_pkg::sat_word(-lav_pkg::round_frac(64'($signed(ds5_q))));
      l2_6_q <= lav_pkg::sat_word(lav_pkg::round_frac(64'($signed(df5_q))));
      s6_q <= s5_q;
      f6_q <= f5_q;
      eye6_q <= eye5_q;
    end
  end

  // dot(u, eye): products, then sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ue7_q[i] <= $signed(u6_q[i]) * $signed(eye6_q[i]);
      end
      u7_q <= u6_q;
      s7_q <= s6_q;
      f7_q <= f6_q;
      l0_7_q <= l0_6_q;
      l2_7_q <= l2_6_q;
      du8_q <= lav_pkg::DU_W'($signed(ue7_q[0])) + lav_pkg::DU_W'($signed(ue7_q[1]))
               + lav_pkg::DU_W'($signed(ue7_q[2]));
      u8_q <= u7_q;
      s8_q <= s7_q;
      f8_q <= f7_q;
      l0_8_q <= l0_7_q;
      l2_8_q <= l2_7_q;
    end
  end

  // Matrix assembly.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        mat9_q[r][0] <= DW'($signed(s8_q[r]));
        mat9_q[r][1] <= DW'($signed(u8_q[r]));
        mat9_q[r][2] <= DW'(-$signed(f8_q[r]));
        mat9_q[r][3] <= '0;
      end
      mat9_q[3][0] <= l0_8_q;
      mat9_q[3][1] <= lav_pkg::sat_word(-lav_pkg::round_frac(64'($signed(du8_q))));
      mat9_q[3][2] <= l2_8_q;
      mat9_q[3][3] <= lav_pkg::ONE;
    end
  end

  lav_rows u_rows (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (v9_q),
    .ready_o(rows_ready),
    .mat_i  (mat9_q),
    .out_o  (out_o)
  );

  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v0_q)
    else $error("accepted transaction not captured");

  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v9_q && !en) |=> (v9_q && $stable(mat9_q)))
    else $error("stalled matrix changed");

endmodule

// ----- tb/sv/look_at_view_matrix_core_tb.sv -----
`timescale 1ns / 100ps

module look_at_view_matrix_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [lav_pkg::DW-1:0] eye[3];
    logic signed [lav_pkg::DW-1:0] ctr[3];
    logic signed [lav_pkg::DW-1:0] up[3];
  } view_req_t;

  typedef struct {
    logic [lav_pkg::ROW_W-1:0] row;
    logic [lav_pkg::DW-1:0] c0;
    logic [lav_pkg::DW-1:0] c1;
    logic [lav_pkg::DW-1:0] c2;
    logic [lav_pkg::DW-1:0] c3;
    logic last;
  } row_res_t;

  logic clk_i;
  logic rst_ni;
  lav_in_if in_if ();
  lav_out_if out_if ();

  look_at_view_matrix_core i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if.sink),
    .out_o(out_if.source)
  );

  row_res_t expected_rows[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_stall_off = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Magnitude of a 64-bit signed value.
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? 64'd0 - v : v;
  endfunction

  // Integer square root, floor.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Unit vector in fixed point; the zero vector stays zero.
  task automatic unit_vec(input logic signed [63:0] v[3], output logic signed [63:0] r[3]);
    logic [63:0] a[3];
    logic [63:0] mx;
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = mag64(v[i]);
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) r[i] = 0;
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += a[i] * a[i];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << lav_pkg::FB) + (len >> 1)) / len;
      r[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
  endtask

  function automatic logic signed [63:0] rnd_half_away(input logic signed [63:0] p);
    logic [63:0] a;
    a = (mag64(p) + (64'd1 << (lav_pkg::FB - 1))) >> lav_pkg::FB;
    return p < 0 ? -$signed(a) : $signed(a);
  endfunction

  function automatic logic [lav_pkg::DW-1:0] clamp_word(input logic signed [63:0] v);
    if (v > lav_pkg::WMAX) return lav_pkg::WMAX[lav_pkg::DW-1:0];
    if (v < lav_pkg::WMIN) return lav_pkg::WMIN[lav_pkg::DW-1:0];
    return v[lav_pkg::DW-1:0];
  endfunction

  // Compute the four expected matrix rows for one request.
  task automatic predict_view_rows(input view_req_t rq);
    logic signed [63:0] eye[3], d[3], f[3], c[3], s[3], u[3], up[3];
    logic signed [63:0] tail[3];
    row_res_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = rq.eye[i];
      up[i] = rq.up[i];
      d[i] = 64'(rq.ctr[i]) - 64'(rq.eye[i]);
    end
    unit_vec(d, f);
    c[0] = f[1] * up[2] - f[2] * up[1];
    c[1] = f[2] * up[0] - f[0] * up[2];
    c[2] = f[0] * up[1] - f[1] * up[0];
    unit_vec(c, s);
    c[0] = s[1] * f[2] - s[2] * f[1];
    c[1] = s[2] * f[0] - s[0] * f[2];
    c[2] = s[0] * f[1] - s[1] * f[0];
    for (int i = 0; i < 3; i++) u[i] = rnd_half_away(c[i]);
    tail[0] = rnd_half_away(-(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]));
    tail[1] = rnd_half_away(-(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]));
    tail[2] = rnd_half_away(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
    for (int i = 0; i < 3; i++) begin
      r.row = lav_pkg::ROW_W'(i);
      r.c0 = clamp_word(s[i]);
      r.c1 = clamp_word(u[i]);
      r.c2 = clamp_word(-f[i]);
      r.c3 = '0;
      r.last = 1'b0;
      expected_rows.push_back(r);
    end
    r.row = lav_pkg::LAST_ROW;
    r.c0 = clamp_word(tail[0]);
    r.c1 = clamp_word(tail[1]);
    r.c2 = clamp_word(tail[2]);
    r.c3 = lav_pkg::ONE;
    r.last = 1'b1;
    expected_rows.push_back(r);
  endtask

  // Send one request after a random idle gap; valid stays high afterwards
  // so that a following request with no gap goes out back to back.
  task automatic send_view(input view_req_t rq, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.eye_x <= rq.eye[0];
    in_if.eye_y <= rq.eye[1];
    in_if.eye_z <= rq.eye[2];
    in_if.center_x <= rq.ctr[0];
    in_if.center_y <= rq.ctr[1];
    in_if.center_z <= rq.ctr[2];
    in_if.up_x <= rq.up[0];
    in_if.up_y <= rq.up[1];
    in_if.up_z <= rq.up[2];
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_view_rows(rq);
    @(negedge clk_i);
  endtask

  function automatic logic [lav_pkg::DW-1:0] rand_coord(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000000)) - 1000000;
      2: return $signed($urandom_range(0, 40)) - 20;
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)} << 4;
    endcase
  endfunction

  function automatic view_req_t rand_view();
    view_req_t rq;
    int kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      rq.eye[i] = rand_coord(kind);
      rq.ctr[i] = rand_coord($urandom_range(0, 3));
      rq.up[i] = rand_coord($urandom_range(0, 3));
    end
    // Now and then make degenerate geometry.
    if ($urandom_range(0, 15) == 0) rq.ctr = rq.eye;
    if ($urandom_range(0, 15) == 0) begin
      for (int i = 0; i < 3; i++) rq.up[i] = rq.ctr[i] - rq.eye[i];
    end
    return rq;
  endfunction

  function automatic view_req_t mk_view(input logic signed [lav_pkg::DW-1:0] e0, e1, e2,
                                        c0, c1, c2, u0, u1, u2);
    view_req_t rq;
    rq.eye = '{e0, e1, e2};
    rq.ctr = '{c0, c1, c2};
    rq.up = '{u0, u1, u2};
    return rq;
  endfunction

  // Stop sending and wait until every expected row has arrived.
  task automatic wait_for_rows();
    in_if.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
  endtask

  // Directed cases: typical view, degenerate vectors and field extremes.
  task automatic test_directed();
    logic signed [lav_pkg::DW-1:0] mx, mn, one;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    one = 32'sh00010000;
    send_view(mk_view(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
    send_view(mk_view(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0));
    send_view(mk_view(0, 0, 0, one, 0, 0, 4 * one, 0, 0));
    send_view(mk_view(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_view(mk_view(mn, mn, mn, mx, mx, mx, 0, one, 0));
    send_view(mk_view(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    send_view(mk_view(mx, mn, mx, mn, mx, mn, mn, mn, mn));
    send_view(mk_view(mn, 0, mx, 0, mx, mn, mx, mx, mx));
    send_view(mk_view(-1, -1, -1, 1, 1, 1, -1, 1, -1));
    send_view(mk_view(0, 0, 0, 1, 0, 0, 0, 0, 1));
    send_view(mk_view(-32'sd5, 7, 3, 0, 0, 0, 0, 0, 0));
    send_view(mk_view(mx, 0, 0, mx - 1, 0, 0, 0, mn, 0));
    send_view(mk_view(one, one, one, -one, -one, -one, one, -one, 0));
    send_view(mk_view(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
                      32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
                      32'sh55555555, 32'shAAAAAAAA, 32'sh55555555));
  endtask

  // Random requests with random gaps.
  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) send_view(rand_view());
  endtask

  // Stall-free back-to-back requests, a drain, then more with stalls.
  task automatic test_burst_and_drain();
    rx_stall_off = 1;
    for (int n = 0; n < 30; n++) send_view(rand_view(), 1);
    wait_for_rows();
    rx_stall_off = 0;
    for (int n = 0; n < 10; n++) send_view(rand_view(), 1);
  endtask

  // Result receiver with random stalls.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = rx_stall_off ? 0 : $urandom_range(0, 15);
      if (stall > 0 && $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  // Compare each accepted row against the oldest expected row.
  always @(posedge clk_i) begin
    row_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row transaction row=%0d", $realtime, out_if.row_index);
        errors++;
      end else begin
        e = expected_rows.pop_front();
        if (out_if.row_index !== e.row || out_if.col0 !== e.c0 || out_if.col1 !== e.c1 ||
            out_if.col2 !== e.c2 || out_if.col3 !== e.c3 || out_if.last_row !== e.last) begin
          $display("%0t: row mismatch exp row=%0d %h %h %h %h last=%b",
                   $realtime, e.row, e.c0, e.c1, e.c2, e.c3, e.last);
          $display("%0t:              act row=%0d %h %h %h %h last=%b",
                   $realtime, out_if.row_index, out_if.col0, out_if.col1, out_if.col2,
                   out_if.col3, out_if.last_row);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.eye_x = '0;
    in_if.eye_y = '0;
    in_if.eye_z = '0;
    in_if.center_x = '0;
    in_if.center_y = '0;
    in_if.center_z = '0;
    in_if.up_x = '0;
    in_if.up_y = '0;
    in_if.up_z = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_burst_and_drain();
    test_random(355);
    wait_for_rows();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- look_at_view_matrix_core.f -----
rtl/lav_pkg.sv
rtl/lav_in_if.sv
rtl/lav_out_if.sv
rtl/lav_norm.sv
rtl/lav_rows.sv
rtl/look_at_view_matrix_core.sv
tb/sv/look_at_view_matrix_core_tb.sv
